// ===== sv/fia_pkg.sv =====
// ----------------------------------------------------------------------------
// fia_pkg
// shared constants for the frame interval averager: command codes, field
// widths and register reset values
// ----------------------------------------------------------------------------
package fia_pkg;

  localparam int unsigned TS_W   = 48;
  localparam int unsigned AVG_W  = 32;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned TPS_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd3;

  localparam logic [TPS_W-1:0] TPS_RESET = 32'd10000000;

endpackage

// ===== sv/fia_ram.sv =====
// ----------------------------------------------------------------------------
// fia_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/frame_interval_averager.sv =====
// ----------------------------------------------------------------------------
// frame_interval_averager
// frame timer: windowed mean frame interval, frame rate and run time
// ----------------------------------------------------------------------------
// input transaction: tuser carries the command (tick, start, stop, reset),
// tdata the 48-bit timestamp of a free-running counter. every input
// transaction gives exactly one output transaction with the mean interval,
// the latched frame rate, the run time with paused time removed and the
// paused flag. the user must write ticks_per_second through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block does not enforce it.
// a running tick passes through cmd, diff, gate, update and divset, then the
// bit-serial divider that forms sum / fill one quotient bit a cycle, then
// total and out; a tick that leaves the window empty skips the divider.
// start, stop, reset and a tick while paused go from cmd straight to total
// and out. the sequencer works on one transaction at a time: tready is low
// from acceptance until its result is in the output register, so no new
// transaction is accepted while one is in flight.
// a stalled receiver holds the result in the output register and the next
// transaction is accepted meanwhile; its result waits until that one is
// taken. rst_ni returns to running with all times, counts and the average
// at zero and ticks_per_second at 10000000.
// ----------------------------------------------------------------------------
module frame_interval_averager #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [47:0]  s_axis_tdata_i,   // timestamp
  input  logic [1:0]   s_axis_tuser_i,   // func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,   // avg_interval, frame_rate, total_time
  output logic         m_axis_tuser_o    // is_stopped
);
  import fia_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = AVG_W + FILL_W;
  localparam int unsigned CNT_W  = $clog2(SUM_W + 1);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SUM_W - 1);
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMD    = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_GATE   = 4'd3;
  localparam logic [3:0] S_UPDATE = 4'd4;
  localparam logic [3:0] S_DIVSET = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_TOTAL  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  logic [TPS_W-1:0]  tps_q;
  logic [FUNC_W-1:0] func_q;
  logic [TS_W-1:0]   ts_q;

  logic [TS_W-1:0]   last_q, cur_q, base_q, paused_q, stop_q;
  logic              stopped_q;
  logic [FILL_W-1:0] fill_q;
  logic [HEAD_W-1:0] head_q;
  logic [SUM_W-1:0]  sum_q;
  logic [AVG_W-1:0]  avg_q;
  logic [RATE_W-1:0] frames_q, latched_q;
  logic [TS_W-1:0]   accum_q;

  logic [TS_W-1:0]   interval_q, diff_q, tot_q;
  logic              pass_q;
  logic [AVG_W-1:0]  stored_q, old_q;
  logic [FILL_W-1:0] rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              m_valid_q;
  logic [AVG_W-1:0]  avg_out_q;
  logic [RATE_W-1:0] rate_out_q;
  logic [TS_W-1:0]   tot_out_q;
  logic              stop_out_q;

  logic [AVG_W-1:0]  ram_rdata;
  logic              ram_we;

  logic              in_fire, out_free;
  logic [TS_W:0]     accum_sum;
  logic [TS_W-1:0]   interval_ext_avg;
  logic [RATE_W-1:0] frames_inc;
  logic [FILL_W:0]   rem_sh;
  logic              div_ge;
  logic [FILL_W:0]   rem_sub;
  logic [SUM_W-1:0]  quo_next;
  logic [AVG_W-1:0]  quo_sat;

  fia_ram #(
    .Width (AVG_W),
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (stored_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign ram_we   = (state_q == S_UPDATE) && pass_q;

  assign accum_sum        = {1'b0, accum_q} + {1'b0, interval_q};
  assign interval_ext_avg = {{(TS_W-AVG_W){1'b0}}, avg_q};
  assign frames_inc       = (frames_q == RATE_MAX) ? RATE_MAX : frames_q + 1'b1;

  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign div_ge   = rem_sh >= {1'b0, fill_q};
  assign rem_sub  = rem_sh - {1'b0, fill_q};
  assign quo_next = {quo_q[SUM_W-2:0], div_ge};
  assign quo_sat  = (|quo_next[SUM_W-1:AVG_W]) ? '1 : quo_next[AVG_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_CMD;
      S_CMD: begin
        if (func_q == FUNC_TICK && !stopped_q) begin
          state_d = S_DIFF;
        end else begin
          state_d = S_TOTAL;
        end
      end
      S_DIFF:   state_d = S_GATE;
      S_GATE:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_DIVSET;
      S_DIVSET: state_d = (fill_q == '0) ? S_TOTAL : S_DIV;
      S_DIV:    if (cnt_q == CNT_LAST) state_d = S_TOTAL;
      S_TOTAL:  state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tps_q     <= TPS_RESET;
      last_q    <= '0;
      cur_q     <= '0;
      base_q    <= '0;
      paused_q  <= '0;
      stop_q    <= '0;
      stopped_q <= 1'b0;
      fill_q    <= '0;
      head_q    <= '0;
      sum_q     <= '0;
      avg_q     <= '0;
      frames_q  <= '0;
      latched_q <= '0;
      accum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      case (state_q)
        S_CMD: begin
          case (func_q)
            FUNC_TICK: begin
              if (stopped_q) begin
                avg_q <= '0;
              end else begin
                cur_q  <= ts_q;
                last_q <= ts_q;
              end
            end
            FUNC_START: begin
              if (stopped_q) begin
                paused_q  <= paused_q + (ts_q - stop_q);
                last_q    <= ts_q;
                cur_q     <= ts_q;
                stop_q    <= '0;
                stopped_q <= 1'b0;
              end
            end
            FUNC_STOP: begin
              if (!stopped_q) begin
                stop_q    <= ts_q;
                stopped_q <= 1'b1;
              end
            end
            default: begin
              base_q    <= ts_q;
              last_q    <= ts_q;
              cur_q     <= ts_q;
              stop_q    <= '0;
              paused_q  <= '0;
              stopped_q <= 1'b0;
            end
          endcase
        end
        S_DIFF: begin
          accum_q <= accum_sum[TS_W] ? '1 : accum_sum[TS_W-1:0];
        end
        S_GATE: begin
          if (accum_q > {{(TS_W-TPS_W){1'b0}}, tps_q}) begin
            latched_q <= frames_inc;
            frames_q  <= '0;
            accum_q   <= '0;
          end else begin
            frames_q <= frames_inc;
          end
        end
        S_UPDATE: begin
          if (pass_q) begin
            sum_q  <= sum_q - {{FILL_W{1'b0}}, old_q} + {{FILL_W{1'b0}}, stored_q};
            head_q <= (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
            if (fill_q != FILL_FULL) begin
              fill_q <= fill_q + 1'b1;
            end
          end
        end
        S_DIVSET: begin
          if (fill_q == '0) begin
            avg_q <= '0;
          end
        end
        S_DIV: begin
          if (cnt_q == CNT_LAST) begin
            avg_q <= quo_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers of the datapath and the divider
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser_i;
      ts_q   <= s_axis_tdata_i;
    end
    case (state_q)
      S_CMD: begin
        interval_q <= ts_q - last_q;
      end
      S_DIFF: begin
        diff_q <= (interval_q >= interval_ext_avg) ? interval_q - interval_ext_avg
                                                   : interval_ext_avg - interval_q;
      end
      S_GATE: begin
        pass_q   <= diff_q < {{(TS_W-TPS_W){1'b0}}, tps_q};
        stored_q <= (|interval_q[TS_W-1:AVG_W]) ? '1 : interval_q[AVG_W-1:0];
        old_q    <= (fill_q == FILL_FULL) ? ram_rdata : '0;
      end
      S_DIVSET: begin
        rem_q <= '0;
        quo_q <= sum_q;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
        quo_q <= quo_next;
        cnt_q <= cnt_q + 1'b1;
      end
      S_TOTAL: begin
        tot_q <= (stopped_q ? stop_q : cur_q) - paused_q;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      avg_out_q  <= stopped_q ? '0 : avg_q;
      rate_out_q <= latched_q;
      tot_out_q  <= tot_q - base_q;
      stop_out_q <= stopped_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {tot_out_q, rate_out_q, avg_out_q};
  assign m_axis_tuser_o  = stop_out_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill beyond depth");

  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= HEAD_LAST)
    else $error("window head beyond depth");

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= CNT_LAST)
    else $error("divider ran past its last step");

  a_paused_avg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && stop_out_q |-> avg_out_q == '0)
    else $error("nonzero average while paused");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("transaction accepted while busy");

endmodule
